>>> design/stt_pkg.sv
// Shared types, constants and character-class functions for the source text tokenizer.
// Used by every module of the block; depends on nothing.
package stt_pkg;

	// Token kinds
	localparam logic [4:0] KIND_EOF           = 5'd0;
	localparam logic [4:0] KIND_IDENT         = 5'd1;
	localparam logic [4:0] KIND_NUMBER        = 5'd2;
	localparam logic [4:0] KIND_STRING        = 5'd3;
	localparam logic [4:0] KIND_KW_FIRST      = 5'd4;
	localparam logic [4:0] KIND_PLUS          = 5'd12;
	localparam logic [4:0] KIND_MINUS         = 5'd13;
	localparam logic [4:0] KIND_STAR          = 5'd14;
	localparam logic [4:0] KIND_SLASH         = 5'd15;
	localparam logic [4:0] KIND_SEMI          = 5'd16;
	localparam logic [4:0] KIND_COMMA         = 5'd17;
	localparam logic [4:0] KIND_DOT           = 5'd18;
	localparam logic [4:0] KIND_LPAREN        = 5'd19;
	localparam logic [4:0] KIND_RPAREN        = 5'd20;
	localparam logic [4:0] KIND_LBRACE        = 5'd21;
	localparam logic [4:0] KIND_RBRACE        = 5'd22;
	localparam logic [4:0] KIND_BADCHAR       = 5'd23;
	localparam logic [4:0] KIND_UNTERMINATED  = 5'd24;

	// Length reported for an unterminated string (length of its message)
	localparam int UNTERM_MSG_LEN = 19;

	// Characters with a special role
	localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
	localparam logic [7:0] CHAR_QUOTE      = 8'h22;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_DOT        = 8'h2E;
	localparam logic [7:0] CHAR_NUL        = 8'h00;

	// Keyword table, left-justified with zero padding, in kind order
	localparam int NUM_KEYWORDS = 8;
	localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
		"function",
		{"class", 24'h0},
		{"if", 48'h0},
		{"else", 32'h0},
		{"while", 24'h0},
		{"return", 16'h0},
		{"true", 32'h0},
		{"false", 24'h0}
	};
	localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd8, 4'd5, 4'd2, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5
	};

	// Most tokens one source byte can release, and depth of the token queue
	localparam int BUNDLE_TOKENS = 3;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// Scanner mode
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING
	} scan_mode_t;

	// Input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_source;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [7:0]  token_length;
		logic        last_of_run;
	} token_t;

	// All tokens released by one source byte
	typedef struct packed {
		logic [1:0]                    count;
		token_t [BUNDLE_TOKENS-1:0]    tok;
	} bundle_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	// Kind of a lone byte met between tokens: an operator or a bad character.
	function automatic logic [4:0] op_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h2B: k = KIND_PLUS;
			8'h2D: k = KIND_MINUS;
			8'h2A: k = KIND_STAR;
			8'h2F: k = KIND_SLASH;
			8'h3B: k = KIND_SEMI;
			8'h2C: k = KIND_COMMA;
			8'h2E: k = KIND_DOT;
			8'h28: k = KIND_LPAREN;
			8'h29: k = KIND_RPAREN;
			8'h7B: k = KIND_LBRACE;
			8'h7D: k = KIND_RBRACE;
			default: k = KIND_BADCHAR;
		endcase
		return k;
	endfunction

	// Identifier or keyword. Window bytes past the length are zero, so a full compare works.
	function automatic logic [4:0] ident_kind(input logic [63:0] win, input logic [15:0] len);
		logic [4:0] k;
		k = KIND_IDENT;
		for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
			if (len == 16'(KW_LEN[i]) && win == KW_TEXT[i]) begin
				k = KIND_KW_FIRST + 5'(i);
			end
		end
		return k;
	endfunction

endpackage

>>> design/stt_stream_if.sv
// Valid/ready stream interface used for the byte input and the token output.
// Payload type is given at instantiation; depends on nothing.
interface stt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> design/stt_front.sv
// Front end: accepts source bytes, runs the scanner state and forms the token bundle per byte.
// Depends on stt_pkg and stt_stream_if.
module stt_front #(
	parameter int KEYWORD_CHARS    = 8,
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int POSITION_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	stt_stream_if.sink        text,
	input  logic              q_full,
	output logic              push,
	output stt_pkg::bundle_t  push_bundle
);

	localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LENGTH);
	localparam int UNTERM_INT = (stt_pkg::UNTERM_MSG_LEN < MAX_TOKEN_LENGTH) ?
		stt_pkg::UNTERM_MSG_LEN : MAX_TOKEN_LENGTH;
	localparam logic [LW-1:0] UNTERM_LEN = LW'(UNTERM_INT);
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	typedef struct packed {
		stt_pkg::scan_mode_t                 mode;
		logic [KEYWORD_CHARS-1:0][7:0]       win;
		logic [LW-1:0]                       len;
		logic [POSITION_BITS-1:0]            line;
		logic [POSITION_BITS-1:0]            col;
	} scan_t;

	typedef struct packed {
		scan_t             st;
		stt_pkg::bundle_t  bun;
	} step_t;

	scan_t scan_q;
	scan_t scan_d;
	step_t step_w;
	logic  accept;

	// Advance line and column past one byte, saturating both.
	function automatic scan_t consume(input scan_t s, input logic [7:0] c);
		scan_t r;
		r = s;
		if (c == stt_pkg::CHAR_NEWLINE) begin
			if (r.line != '1) begin
				r.line = r.line + POS_ONE;
			end
			r.col = POS_ONE;
		end else if (r.col != '1) begin
			r.col = r.col + POS_ONE;
		end
		return r;
	endfunction

	// Add one byte to the pending token.
	function automatic scan_t grow(input scan_t s, input logic [7:0] c);
		scan_t r;
		r = s;
		for (int i = 0; i < KEYWORD_CHARS; i++) begin
			if (32'(s.len) == i) begin
				r.win[i] = c;
			end
		end
		if (r.len != LEN_MAX) begin
			r.len = r.len + LW'(1);
		end
		return r;
	endfunction

	function automatic scan_t start(input scan_t s, input stt_pkg::scan_mode_t m);
		scan_t r;
		r = s;
		r.mode = m;
		r.len = '0;
		r.win = '0;
		return r;
	endfunction

	function automatic logic [7:0] len8(input logic [LW-1:0] l);
		logic [31:0] w;
		w = 32'(l);
		return w[7:0];
	endfunction

	function automatic logic [4:0] pending_ident_kind(input scan_t s);
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			w[63-8*i -: 8] = s.win[i];
		end
		return stt_pkg::ident_kind(w, 16'(s.len));
	endfunction

	// Append a token stamped with the current position.
	function automatic stt_pkg::bundle_t emit(input stt_pkg::bundle_t b, input scan_t s,
			input logic [4:0] kind, input logic [7:0] len);
		stt_pkg::bundle_t r;
		logic [31:0]      line32;
		logic [31:0]      col32;
		r = b;
		line32 = 32'(s.line);
		col32 = 32'(s.col);
		r.tok[r.count].token_kind = kind;
		r.tok[r.count].token_line = line32[15:0];
		r.tok[r.count].token_column = col32[15:0];
		r.tok[r.count].token_length = len;
		r.tok[r.count].last_of_run = 1'b0;
		r.count = r.count + 2'd1;
		return r;
	endfunction

	// A byte seen between tokens.
	function automatic step_t scan_idle(input step_t p, input logic [7:0] c);
		step_t r;
		r = p;
		if (stt_pkg::is_space(c)) begin
			r.st = consume(r.st, c);
		end else if (stt_pkg::is_letter(c)) begin
			r.st = consume(grow(start(r.st, stt_pkg::MODE_IDENT), c), c);
		end else if (stt_pkg::is_digit(c)) begin
			r.st = consume(grow(start(r.st, stt_pkg::MODE_NUMBER), c), c);
		end else if (c == stt_pkg::CHAR_QUOTE) begin
			r.st = consume(start(r.st, stt_pkg::MODE_STRING), c);
		end else begin
			r.st = consume(r.st, c);
			r.bun = emit(r.bun, r.st, stt_pkg::op_kind(c), 8'd1);
		end
		return r;
	endfunction

	// One source byte: new scanner state and the tokens it releases.
	function automatic step_t scan_step(input scan_t s, input stt_pkg::in_beat_t beat);
		step_t       r;
		logic [7:0]  c;
		logic        last;
		c = beat.text_byte;
		last = beat.end_of_source || (c == stt_pkg::CHAR_NUL);
		r.st = s;
		r.bun = '0;
		if (c != stt_pkg::CHAR_NUL) begin
			case (r.st.mode)
				stt_pkg::MODE_IDENT: begin
					if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c) ||
							c == stt_pkg::CHAR_UNDERSCORE) begin
						r.st = consume(grow(r.st, c), c);
					end else begin
						r.bun = emit(r.bun, r.st, pending_ident_kind(r.st), len8(r.st.len));
						r.st = start(r.st, stt_pkg::MODE_IDLE);
						r = scan_idle(r, c);
					end
				end
				stt_pkg::MODE_NUMBER: begin
					if (stt_pkg::is_digit(c) || c == stt_pkg::CHAR_DOT) begin
						r.st = consume(grow(r.st, c), c);
					end else begin
						r.bun = emit(r.bun, r.st, stt_pkg::KIND_NUMBER, len8(r.st.len));
						r.st = start(r.st, stt_pkg::MODE_IDLE);
						r = scan_idle(r, c);
					end
				end
				stt_pkg::MODE_STRING: begin
					r.st = consume(r.st, c);
					if (c == stt_pkg::CHAR_QUOTE) begin
						r.bun = emit(r.bun, r.st, stt_pkg::KIND_STRING, len8(r.st.len));
						r.st = start(r.st, stt_pkg::MODE_IDLE);
					end else begin
						r.st = grow(r.st, c);
					end
				end
				default: begin
					r = scan_idle(r, c);
				end
			endcase
		end
		if (last) begin
			case (r.st.mode)
				stt_pkg::MODE_IDENT: begin
					r.bun = emit(r.bun, r.st, pending_ident_kind(r.st), len8(r.st.len));
				end
				stt_pkg::MODE_NUMBER: begin
					r.bun = emit(r.bun, r.st, stt_pkg::KIND_NUMBER, len8(r.st.len));
				end
				stt_pkg::MODE_STRING: begin
					r.bun = emit(r.bun, r.st, stt_pkg::KIND_UNTERMINATED, len8(UNTERM_LEN));
				end
				default: begin
				end
			endcase
			r.bun = emit(r.bun, r.st, stt_pkg::KIND_EOF, 8'd0);
			r.st = start(r.st, stt_pkg::MODE_IDLE);
			r.st.line = POS_ONE;
			r.st.col = POS_ONE;
		end
		if (r.bun.count != 2'd0) begin
			r.bun.tok[r.bun.count - 2'd1].last_of_run = 1'b1;
		end
		return r;
	endfunction

	assign accept = text.valid && text.ready;
	assign step_w = scan_step(scan_q, text.payload);

	// Next scanner state: taken only on an accepted beat.
	always_comb begin
		scan_d = scan_q;
		if (accept) begin
			scan_d = step_w.st;
		end
	end

	// Handshake and queue write.
	always_comb begin
		text.ready = !q_full;
		push = accept && (step_w.bun.count != 2'd0);
		push_bundle = step_w.bun;
	end

	// Scanner state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q.mode <= stt_pkg::MODE_IDLE;
			scan_q.win <= '0;
			scan_q.len <= '0;
			scan_q.line <= POS_ONE;
			scan_q.col <= POS_ONE;
		end else begin
			scan_q <= scan_d;
		end
	end

endmodule

>>> design/stt_queue.sv
// Short queue of token bundles between the scanner and the output serialiser.
// Depends on stt_pkg.
module stt_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  stt_pkg::bundle_t        push_bundle,
	input  logic                    pop,
	output stt_pkg::bundle_t        head,
	output stt_pkg::queue_status_t  status
);

	localparam logic [stt_pkg::QAW:0] LEVEL_FULL = (stt_pkg::QAW + 1)'(stt_pkg::QDEPTH);
	localparam logic [stt_pkg::QAW:0] LEVEL_ONE = (stt_pkg::QAW + 1)'(1);
	localparam logic [stt_pkg::QAW-1:0] PTR_ONE = (stt_pkg::QAW)'(1);

	stt_pkg::bundle_t          mem_q [stt_pkg::QDEPTH];
	logic [stt_pkg::QAW-1:0]   wr_ptr_q;
	logic [stt_pkg::QAW-1:0]   rd_ptr_q;
	logic [stt_pkg::QAW:0]     level_q;

	// Status and head entry.
	always_comb begin
		status.full = (level_q == LEVEL_FULL);
		status.empty = (level_q == '0);
		head = mem_q[rd_ptr_q];
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				level_q <= level_q + LEVEL_ONE;
			end else if (pop && !push) begin
				level_q <= level_q - LEVEL_ONE;
			end
		end
	end

endmodule

>>> design/stt_back.sv
// Back end: takes bundles from the queue and delivers their tokens one beat at a time
// through an output register. Depends on stt_pkg and stt_stream_if.
module stt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stt_pkg::bundle_t        head,
	input  stt_pkg::queue_status_t  status,
	output logic                    pop,
	stt_stream_if.source            tokens
);

	logic             out_valid_q;
	stt_pkg::token_t  out_tok_q;
	logic [1:0]       idx_q;
	logic             load;
	logic             bundle_done;

	// Load the next token, when the queue holds one, whenever the output register is free or being drained.
	always_comb begin
		load = !status.empty && (!out_valid_q || tokens.ready);
		bundle_done = (idx_q == (head.count - 2'd1));
		pop = load && bundle_done;
		tokens.valid = out_valid_q;
		tokens.payload = out_tok_q;
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q <= head.tok[idx_q];
		end
	end

	// Output valid and position within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q <= bundle_done ? 2'd0 : idx_q + 2'd1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/source_text_tokenizer.sv
// Streaming tokenizer: source bytes in on text, tokens out on tokens.
// Depends on stt_pkg, stt_stream_if, stt_front, stt_queue and stt_back.
//
// One source byte is accepted per clock while the queue is not full. A byte releases
// zero to three tokens, which travel as one bundle through a four-entry queue and leave
// one token per clock, while tokens.ready is high, from an output register. Sustained
// input rate is one byte per cycle while bytes release at most one token each on average
// and the sink stays ready; a byte releasing several tokens delivers them one beat at a
// time, and text.ready falls only when the queue is full. Each token carries its kind,
// the line and the column just past its last byte, its length and a flag on the last
// token of a byte. A zero byte or end_of_source closes the source with an end-of-source
// token and returns the position to line 1, column 1.
module source_text_tokenizer #(
	parameter int KEYWORD_CHARS    = 8,
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int POSITION_BITS    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	stt_stream_if.sink    text,
	stt_stream_if.source  tokens
);

	logic                    push;
	logic                    pop;
	stt_pkg::bundle_t        push_bundle;
	stt_pkg::bundle_t        head;
	stt_pkg::queue_status_t  q_status;

	stt_front #(
		.KEYWORD_CHARS    (KEYWORD_CHARS),
		.MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
		.POSITION_BITS    (POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.q_full      (q_status.full),
		.push        (push),
		.push_bundle (push_bundle)
	);

	stt_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.head        (head),
		.status      (q_status)
	);

	stt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.status  (q_status),
		.pop     (pop),
		.tokens  (tokens)
	);

	// The end-of-source token always closes the tokens of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.payload.token_kind == stt_pkg::KIND_EOF
		|-> tokens.payload.last_of_run)
		else $error("end-of-source token without last_of_run");

	// Positions never fall to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid |-> tokens.payload.token_line != 16'd0 &&
		tokens.payload.token_column != 16'd0)
		else $error("token position is zero");

	// The queue is never written while full, nor read while empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full) && !(pop && q_status.empty))
		else $error("token queue overrun or underrun");

	// A queue that was empty and not written stays empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty && !push |=> q_status.empty)
		else $error("token queue filled without a write");

endmodule

>>> tb/sv/tb_token_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the source text tokenizer: predicts the tokens of each accepted byte and
// compares them with the token beats leaving the block. Depends on stt_pkg.
module tb_token_checker
	import stt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	input  logic     src_ready,
	input  in_beat_t src_beat,
	input  logic     tok_valid,
	input  logic     tok_ready,
	input  token_t   tok_beat,
	output int       fail_count,
	output int       outstanding
);

	localparam int POS_LIMIT  = 65535;
	localparam int LEN_LIMIT  = 255;
	localparam int WINDOW     = 8;
	localparam int NUM_OPS    = 11;
	localparam int REPORT_MAX = 10;

	// Operator bytes in token-kind order, starting at the plus sign
	localparam logic [7:0] OPERATORS [NUM_OPS] = '{
		"+", "-", "*", "/", ";", ",", ".", "(", ")", "{", "}"
	};

	string kw_list [8] = '{"function", "class", "if", "else", "while", "return", "true", "false"};

	// Scanner state mirrored from the block
	scan_mode_t mode = MODE_IDLE;
	logic [7:0] window [WINDOW];
	int         text_len = 0;
	int         line_no = 1;
	int         col_no = 1;

	token_t expected_tokens [$];
	token_t run_tokens [$];
	token_t want;
	int     errs = 0;

	function automatic logic letter_c(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic digit_c(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic blank_c(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// A newline moves to the next line; anything else moves one column on.
	function automatic void step_position(input logic [7:0] c);
		if (c == CHAR_NEWLINE) begin
			if (line_no < POS_LIMIT) line_no++;
			col_no = 1;
		end else if (col_no < POS_LIMIT) begin
			col_no++;
		end
	endfunction

	function automatic void take_char(input logic [7:0] c);
		if (text_len < WINDOW) window[text_len] = c;
		if (text_len < LEN_LIMIT) text_len++;
	endfunction

	function automatic void open_token(input scan_mode_t m);
		mode = m;
		text_len = 0;
		for (int i = 0; i < WINDOW; i++) window[i] = 8'h00;
	endfunction

	function automatic void add_token(input logic [4:0] kind, input int len);
		token_t t;
		t.token_kind = kind;
		t.token_line = 16'(line_no);
		t.token_column = 16'(col_no);
		t.token_length = 8'(len);
		t.last_of_run = 1'b0;
		run_tokens.push_back(t);
	endfunction

	// An identifier is a keyword only when its length and every byte agree.
	function automatic logic [4:0] word_kind();
		logic [4:0] k;
		logic       same;
		k = KIND_IDENT;
		for (int w = 0; w < 8; w++) begin
			if (text_len == kw_list[w].len() && k == KIND_IDENT) begin
				same = 1'b1;
				for (int i = 0; i < text_len; i++) begin
					if (window[i] != kw_list[w][i]) same = 1'b0;
				end
				if (same) k = KIND_KW_FIRST + 5'(w);
			end
		end
		return k;
	endfunction

	// A byte met between tokens.
	function automatic void scan_between(input logic [7:0] c);
		logic [4:0] kind;
		if (blank_c(c)) begin
			step_position(c);
		end else if (letter_c(c)) begin
			open_token(MODE_IDENT);
			take_char(c);
			step_position(c);
		end else if (digit_c(c)) begin
			open_token(MODE_NUMBER);
			take_char(c);
			step_position(c);
		end else if (c == CHAR_QUOTE) begin
			open_token(MODE_STRING);
			step_position(c);
		end else begin
			step_position(c);
			kind = KIND_BADCHAR;
			for (int k = 0; k < NUM_OPS; k++) begin
				if (OPERATORS[k] == c) kind = KIND_PLUS + 5'(k);
			end
			add_token(kind, 1);
		end
	endfunction

	function automatic void reset_scanner();
		open_token(MODE_IDLE);
		line_no = 1;
		col_no = 1;
	endfunction

	// Works out every token that one accepted byte releases and queues them in order.
	function automatic void predict_byte(input logic [7:0] c, input logic eos);
		token_t t;
		run_tokens.delete();
		if (c != CHAR_NUL) begin
			case (mode)
				MODE_IDENT: begin
					if (letter_c(c) || digit_c(c) || c == CHAR_UNDERSCORE) begin
						take_char(c);
						step_position(c);
					end else begin
						add_token(word_kind(), text_len);
						open_token(MODE_IDLE);
						scan_between(c);
					end
				end
				MODE_NUMBER: begin
					if (digit_c(c) || c == CHAR_DOT) begin
						take_char(c);
						step_position(c);
					end else begin
						add_token(KIND_NUMBER, text_len);
						open_token(MODE_IDLE);
						scan_between(c);
					end
				end
				MODE_STRING: begin
					step_position(c);
					if (c == CHAR_QUOTE) begin
						add_token(KIND_STRING, text_len);
						open_token(MODE_IDLE);
					end else begin
						take_char(c);
					end
				end
				default: scan_between(c);
			endcase
		end

		// End of source flushes whatever is pending and closes with an end token.
		if (eos || c == CHAR_NUL) begin
			case (mode)
				MODE_IDENT:  add_token(word_kind(), text_len);
				MODE_NUMBER: add_token(KIND_NUMBER, text_len);
				MODE_STRING: add_token(KIND_UNTERMINATED,
					UNTERM_MSG_LEN < LEN_LIMIT ? UNTERM_MSG_LEN : LEN_LIMIT);
				default: ;
			endcase
			add_token(KIND_EOF, 0);
			reset_scanner();
		end

		for (int i = 0; i < run_tokens.size(); i++) begin
			t = run_tokens[i];
			t.last_of_run = (i == run_tokens.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	// Compare leaving tokens first, then predict for the byte taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_scanner();
			expected_tokens.delete();
			outstanding <= 0;
			fail_count <= errs;
		end else begin
			if (tok_valid && tok_ready) begin
				if (expected_tokens.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX) begin
						$write("tb_token_checker: unexpected token kind %0d line %0d col %0d",
							tok_beat.token_kind, tok_beat.token_line, tok_beat.token_column);
						$display(" len %0d last %0b", tok_beat.token_length,
							tok_beat.last_of_run);
					end
				end else begin
					want = expected_tokens.pop_front();
					if (want.token_kind != tok_beat.token_kind ||
						want.token_line != tok_beat.token_line ||
						want.token_column != tok_beat.token_column ||
						want.token_length != tok_beat.token_length ||
						want.last_of_run != tok_beat.last_of_run) begin
						errs++;
						if (errs <= REPORT_MAX) begin
							$write("tb_token_checker: mismatch, expected kind %0d line %0d col %0d",
								want.token_kind, want.token_line, want.token_column);
							$write(" len %0d last %0b,", want.token_length, want.last_of_run);
							$display(" got kind %0d line %0d col %0d len %0d last %0b",
								tok_beat.token_kind, tok_beat.token_line, tok_beat.token_column,
								tok_beat.token_length, tok_beat.last_of_run);
						end
					end
				end
			end
			if (src_valid && src_ready)
				predict_byte(src_beat.text_byte, src_beat.end_of_source);
			outstanding <= expected_tokens.size();
			fail_count <= errs;
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, byte stimulus, token back-pressure and verdict.
// Depends on stt_pkg, stt_stream_if, source_text_tokenizer and tb_token_checker.
module tb_top;
	import stt_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_BYTES = 26;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stt_stream_if #(.payload_t(in_beat_t)) text_ch();
	stt_stream_if #(.payload_t(token_t))   tok_ch();

	int fails;
	int outstanding;

	// Idling controls, changed per phase
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent = 0;

	string keywords [8] = '{"function", "class", "if", "else", "while", "return", "true", "false"};
	string op_bytes = "+-*/;,.(){}=<>";

	source_text_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (tok_ch)
	);

	tb_token_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (text_ch.valid),
		.src_ready   (text_ch.ready),
		.src_beat    (text_ch.payload),
		.tok_valid   (tok_ch.valid),
		.tok_ready   (tok_ch.ready),
		.tok_beat    (tok_ch.payload),
		.fail_count  (fails),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Token sink: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			tok_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_seq) begin
			tok_ch.ready <= 1'b0;
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
		end else begin
			tok_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one byte, after a random number of idle cycles, and waits for its beat.
	task automatic send_byte(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < gap_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.payload <= {c, eos};
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_word(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	function automatic logic [7:0] pick_letter();
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
	endfunction

	// A byte that may continue an identifier.
	function automatic logic [7:0] ident_char();
		case ($urandom_range(3))
			0:       return 8'h30 + 8'($urandom_range(9));
			1:       return CHAR_UNDERSCORE;
			default: return pick_letter();
		endcase
	endfunction

	// One token, which may be ill-formed, or some whitespace or a stray byte.
	task automatic send_random_token();
		int         pick;
		int         n;
		string      s;
		logic [7:0] c;
		pick = $urandom_range(99);
		n = $urandom_range(10);
		if (pick < 15) begin
			s = keywords[$urandom_range(7)];
			case ($urandom_range(4))
				0:       s = {s, "_"};
				1:       s = s.substr(0, s.len() - 2);
				default: ;
			endcase
			send_word(s);
		end else if (pick < 35) begin
			send_byte(pick_letter(), 1'b0);
			repeat (n) send_byte(ident_char(), 1'b0);
		end else if (pick < 50) begin
			send_byte(8'h30 + 8'($urandom_range(9)), 1'b0);
			repeat (n) begin
				c = ($urandom_range(3) == 0) ? CHAR_DOT : 8'h30 + 8'($urandom_range(9));
				send_byte(c, 1'b0);
			end
		end else if (pick < 62) begin
			send_byte(CHAR_QUOTE, 1'b0);
			repeat (n) begin
				case ($urandom_range(9))
					0:       c = CHAR_NEWLINE;
					1, 2:    c = 8'($urandom_range(1, 255));
					default: c = 8'($urandom_range(8'h20, 8'h7E));
				endcase
				if (c == CHAR_QUOTE) c = "'";
				send_byte(c, 1'b0);
			end
			if ($urandom_range(9) != 0) send_byte(CHAR_QUOTE, 1'b0);
		end else if (pick < 82) begin
			send_byte(op_bytes[$urandom_range(op_bytes.len() - 1)], 1'b0);
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 3)) begin
				c = ($urandom_range(2) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
				send_byte(c, 1'b0);
			end
		end else begin
			send_byte(8'($urandom_range(1, 255)), 1'b0);
		end
	endtask

	// Closes the source, by a zero byte or by a flagged final byte.
	task automatic send_end();
		if ($urandom_range(1))
			send_byte(CHAR_NUL, 1'($urandom_range(1)));
		else
			send_byte(8'($urandom_range(1, 255)), 1'b1);
	endtask

	task automatic run_phase(input int budget);
		int end_at;
		end_at = sent + budget;
		while (sent < end_at) begin
			send_random_token();
			if ($urandom_range(29) == 0) send_end();
		end
	endtask

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text: keyword, identifier, string across a newline, number, operators,
		// bad bytes, zero byte, and a pending string and a pending number cut off by end of source.
		send_word("if x_9(\"s\n\"2.5;");
		send_byte(8'hFF, 1'b0);
		send_word("=\t}");
		send_byte(CHAR_NUL, 1'b0);
		send_word("ab");
		send_byte("+", 1'b1);
		send_byte(CHAR_QUOTE, 1'b0);
		send_byte("q", 1'b1);
		send_byte("7", 1'b1);
		send_byte(" ", 1'b1);
		send_byte(CHAR_NUL, 1'b1);

		// An identifier long enough for its length to saturate.
		send_byte(pick_letter(), 1'b0);
		repeat (259) send_byte(ident_char(), 1'b0);
		send_byte(" ", 1'b0);

		// Random text under the different idling patterns.
		run_phase(PHASE_BYTES);
		gap_pct = 65;
		run_phase(PHASE_BYTES);
		gap_pct = 0;
		stall_pct = 65;
		run_phase(PHASE_BYTES);
		gap_pct = 27;
		stall_pct = 27;
		run_phase(PHASE_BYTES);

		// Sink holds off for a long stretch while bytes keep coming, so the queue fills;
		// a run of operators gives one token per byte.
		gap_pct = 0;
		stall_pct = 0;
		hold_seq++;
		send_word("+-*/;,(){}+-*/");
		run_phase(PHASE_BYTES);
		send_byte(CHAR_NUL, 1'b1);
		text_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
